@@ rtl/asrd_pkg.sv @@
// shared types, constants and codes of the audio sample rate divider
package asrd_pkg;

    localparam int CLK_W   = 26;
    localparam int RATE_W  = 32;
    localparam int MANT_W  = 24;
    localparam int QSHIFT  = 25;
    localparam int DVD_W   = MANT_W + QSHIFT;
    localparam int DVS_W   = CLK_W;
    localparam int QUO_W   = CLK_W;
    localparam int CNT_W   = $clog2(DVD_W + 1);
    localparam int NORM_W  = 32;
    localparam int ZCNT_W  = $clog2(NORM_W);
    localparam int EXP_W   = 8;
    localparam int ACT_W   = 27;
    localparam int BITS_W  = 4;
    localparam int CNTR_W  = 32;
    localparam int ST_W    = 2;
    localparam int OUT_W   = 128;

    localparam logic [CLK_W-1:0] CLK_PAL   = CLK_W'(49656530);
    localparam logic [CLK_W-1:0] CLK_NTSC  = CLK_W'(48681812);
    localparam logic [CLK_W-1:0] CLK_MPAL  = CLK_W'(48628316);
    localparam logic [CLK_W-1:0] CLK_RESET = CLK_NTSC;

    localparam logic [CLK_W-1:0] MIN_DIVISOR = CLK_W'(132);
    localparam logic [CLK_W-1:0] BIT_DIV     = CLK_W'(66);
    localparam logic [7:0]       BIT_CLAMP   = 8'd16;
    localparam logic [CNTR_W-1:0] WRITE_INC  = CNTR_W'(3);

    // divisor / 66 as ((divisor >> 1) * ceil(2^31 / 33)) >> 31, exact for 25-bit halves
    localparam logic [CLK_W-1:0] BIT_RECIP    = CLK_W'(65075263);
    localparam int               BIT_RECIP_SH = 31;
    localparam int               BIT_PROD_W   = 2*CLK_W - 1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_TOO_FAST = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT   = 2'd2;

    // launch request for the shared divider
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } div_ctl_t;

endpackage

@@ rtl/asrd_div.sv @@
// shared restoring divider, one quotient bit per cycle
module asrd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  asrd_pkg::div_ctl_t          ctl,
    input  logic [asrd_pkg::DVD_W-1:0]  dividend,
    input  logic [asrd_pkg::DVS_W-1:0]  divisor,
    output logic [asrd_pkg::QUO_W-1:0]  quotient,
    output logic                        rem_nonzero,
    output logic                        done
);
    import asrd_pkg::*;

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DVD_W-1:0] dvd_reg,   dvd_next;
    logic [DVS_W-1:0] dvs_reg,   dvs_next;
    logic [DVS_W-1:0] rem_reg,   rem_next;
    logic [QUO_W-1:0] quo_reg,   quo_next;
    logic [DVS_W:0]   cand;

    assign cand = {rem_reg, dvd_reg[DVD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (cand >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(cand - {1'b0, dvs_reg});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = cand[DVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctl.steps;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign rem_nonzero = |rem_reg;
    assign done        = done_reg;

endmodule

@@ rtl/asrd_norm.sv @@
// shared normalizer: shifts left one bit per cycle, then rounds to a 24-bit significand
module asrd_norm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [asrd_pkg::NORM_W-1:0]  value,
    output logic [asrd_pkg::MANT_W-1:0]  mant,
    output logic [asrd_pkg::EXP_W-1:0]   expo,
    output logic                         done
);
    import asrd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NORM_W-1:0] val_reg,  val_next;
    logic [ZCNT_W-1:0] z_reg,    z_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic [EXP_W-1:0]  exp_reg,  exp_next;
    logic              rnd_up;
    logic [MANT_W:0]   rnd_sum;

    // round to nearest even on the bits below the significand
    assign rnd_up  = val_reg[NORM_W-MANT_W-1]
                     && ((|val_reg[NORM_W-MANT_W-2:0]) || val_reg[NORM_W-MANT_W]);
    assign rnd_sum = {1'b0, val_reg[NORM_W-1:NORM_W-MANT_W]} + (MANT_W+1)'(rnd_up);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        val_next  = val_reg;
        z_next    = z_reg;
        mant_next = mant_reg;
        exp_next  = exp_reg;
        if (busy_reg)
        begin
            if (val_reg[NORM_W-1])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                mant_next = rnd_sum[MANT_W] ? rnd_sum[MANT_W:1] : rnd_sum[MANT_W-1:0];
                exp_next  = EXP_W'(NORM_W - MANT_W) - EXP_W'(z_reg)
                            + EXP_W'(rnd_sum[MANT_W]);
            end
            else
            begin
                val_next = {val_reg[NORM_W-2:0], 1'b0};
                z_next   = z_reg + ZCNT_W'(1);
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            val_next  = value;
            z_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        z_reg    <= z_next;
        mant_reg <= mant_next;
        exp_reg  <= exp_next;
    end

    assign mant = mant_reg;
    assign expo = exp_reg;
    assign done = done_reg;

endmodule

@@ rtl/audio_sample_rate_divider.sv @@
// top level: audio dac divisor from a requested sample rate, single precision rounding
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------------
//  s_*      | in        | tdata[31:0] requested_rate
//  m_*      | out       | tdata: status, actual_rate, dac_rate_value, bit_rate_value,
//           |           |        register_write_count, too_fast_count (zero padded)
//  cfg_*    | in        | cfg_wdata[25:0] video_clock, written when cfg_we is high
//
// one transaction at a time: s_tready is high only while the sequencer is idle
// a rejected request goes straight to the result; a full one passes through the
// shared normalizer for the rate, the shared divider for the significand quotient,
// the normalizer again for the rounded sum and the divider again for clock/divisor;
// divisor/66 is a combinational reciprocal multiply
// a finished result waits in the output register; a new request is taken meanwhile
// reset clears the sequencer, both counters and the output valid; video_clock resets to 48681812
module audio_sample_rate_divider (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [25:0]   cfg_wdata,     // video_clock
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,       // requested_rate
    output logic          m_tvalid,
    input  logic          m_tready,
    // status[1:0], actual_rate[28:2], dac_rate_value[54:29], bit_rate_value[58:55],
    // register_write_count[90:59], too_fast_count[122:91], zeros[127:123]
    output logic [127:0]  m_tdata
);
    import asrd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_NORM_F = 4'd1;   // normalize the requested rate
    localparam logic [3:0] S_DIV_Q  = 4'd2;   // significand quotient
    localparam logic [3:0] S_QRND   = 4'd3;   // round the quotient
    localparam logic [3:0] S_SUM    = 4'd4;   // add one half at the quotient's scale
    localparam logic [3:0] S_NORM_S = 4'd5;   // round the sum, then truncate
    localparam logic [3:0] S_CHECK  = 4'd6;   // too-fast test
    localparam logic [3:0] S_DIV_A  = 4'd7;   // clock / divisor, bit rate alongside
    localparam logic [3:0] S_FINISH = 4'd9;   // hand the result to the output register

    logic [3:0]        state_reg,  state_next;
    logic [CLK_W-1:0]  clk_cfg_reg;
    logic [CNTR_W-1:0] wcnt_reg,   wcnt_next;
    logic [CNTR_W-1:0] fcnt_reg,   fcnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    // work registers
    logic [MANT_W-1:0] mc_reg,     mc_next;
    logic [1:0]        ec_reg,     ec_next;
    logic [MANT_W-1:0] mq_reg,     mq_next;
    logic [EXP_W-1:0]  eq_reg,     eq_next;
    logic [EXP_W-1:0]  s_reg,      s_next;
    logic [CLK_W-1:0]  dv_reg,     dv_next;
    logic [ST_W-1:0]   st_reg,     st_next;
    logic [ACT_W-1:0]  act_reg,    act_next;
    logic [CLK_W-1:0]  dac_reg,    dac_next;
    logic [BITS_W-1:0] bits_reg,   bits_next;

    logic              s_accept;
    logic              clk_known;
    logic [MANT_W:0]   mc_sum;
    logic              mc_up;

    // quotient rounding
    logic [QUO_W:0]    qv;
    logic [MANT_W-1:0] qm0;
    logic              qg, qs, q_up;
    logic [MANT_W:0]   qsum;
    logic [1:0]        qsh;

    // half add and truncation
    logic              eq_ge_m1;
    logic [NORM_W-1:0] sum_val;
    logic [EXP_W-1:0]  t_exp;
    logic [EXP_W-1:0]  t_neg;
    logic [NORM_W-1:0] trunc_val;

    // bit rate clamp
    logic [BIT_PROD_W-1:0] br_prod;
    logic [7:0]        br8;
    logic [4:0]        brc;

    // shared units
    div_ctl_t          div_ctl;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [QUO_W-1:0]  div_quo;
    logic              div_rem_nz;
    logic              div_done;
    logic              norm_start;
    logic [NORM_W-1:0] norm_value;
    logic [MANT_W-1:0] norm_mant;
    logic [EXP_W-1:0]  norm_exp;
    logic              norm_done;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign clk_known = (clk_cfg_reg == CLK_PAL) || (clk_cfg_reg == CLK_NTSC)
                       || (clk_cfg_reg == CLK_MPAL);

    // every known clock is 26 bits long, so its significand drops two bits
    assign mc_up  = clk_cfg_reg[1] && (clk_cfg_reg[0] || clk_cfg_reg[2]);
    assign mc_sum = {1'b0, clk_cfg_reg[CLK_W-1:2]} + (MANT_W+1)'(mc_up);

    // quotient with sticky bit is 26 or 27 bits long
    assign qv = {div_quo, div_rem_nz};
    always_comb
    begin
        if (qv[QUO_W])
        begin
            qm0 = qv[QUO_W:3];
            qg  = qv[2];
            qs  = |qv[1:0];
            qsh = 2'd3;
        end
        else
        begin
            qm0 = qv[QUO_W-1:2];
            qg  = qv[1];
            qs  = qv[0];
            qsh = 2'd2;
        end
    end
    assign q_up = qg && (qs || qm0[0]);
    assign qsum = {1'b0, qm0} + (MANT_W+1)'(q_up);

    // one half added at the scale of the quotient (exponent of -1 or more keeps unit scale)
    assign eq_ge_m1 = !eq_reg[EXP_W-1] || (eq_reg == {EXP_W{1'b1}});
    always_comb
    begin
        if (eq_ge_m1)
            sum_val = (NORM_W'(mq_reg) << (EXP_W'(eq_reg + EXP_W'(1)) & EXP_W'(31)))
                      + NORM_W'(1);
        else
            sum_val = NORM_W'(mq_reg) + (NORM_W'(1) << ((~eq_reg) & EXP_W'(31)));
    end

    // truncation of the rounded sum toward zero
    assign t_exp = norm_exp - s_reg;
    assign t_neg = EXP_W'(0) - t_exp;
    always_comb
    begin
        if (!t_exp[EXP_W-1])
            trunc_val = NORM_W'(norm_mant) << t_exp[ZCNT_W-1:0];
        else if (t_neg >= EXP_W'(NORM_W))
            trunc_val = '0;
        else
            trunc_val = NORM_W'(norm_mant) >> t_neg[ZCNT_W-1:0];
    end

    // divisor / 66 by reciprocal multiply, low byte clamped to 16
    assign br_prod = BIT_PROD_W'(dv_reg[CLK_W-1:1]) * BIT_PROD_W'(BIT_RECIP);
    assign br8 = br_prod[BIT_RECIP_SH+7:BIT_RECIP_SH];
    assign brc = (br8 > BIT_CLAMP) ? BIT_CLAMP[4:0] : br8[4:0];

    always_comb
    begin
        state_next   = state_reg;
        wcnt_next    = wcnt_reg;
        fcnt_next    = fcnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mc_next      = mc_reg;
        ec_next      = ec_reg;
        mq_next      = mq_reg;
        eq_next      = eq_reg;
        s_next       = s_reg;
        dv_next      = dv_reg;
        st_next      = st_reg;
        act_next     = act_reg;
        dac_next     = dac_reg;
        bits_next    = bits_reg;
        norm_start   = 1'b0;
        norm_value   = s_tdata;
        div_ctl      = '{start: 1'b0, steps: CNT_W'(CLK_W)};
        div_dividend = {clk_cfg_reg, (DVD_W-CLK_W)'(0)};
        div_divisor  = dv_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    mc_next = mc_sum[MANT_W] ? mc_sum[MANT_W:1] : mc_sum[MANT_W-1:0];
                    ec_next = mc_sum[MANT_W] ? 2'd3 : 2'd2;
                    if ((s_tdata == '0) || !clk_known)
                    begin
                        st_next    = ST_REJECT;
                        act_next   = '0;
                        dac_next   = '0;
                        bits_next  = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        norm_start = 1'b1;
                        state_next = S_NORM_F;
                    end
                end
            end
            S_NORM_F:
            begin
                if (norm_done)
                begin
                    div_ctl      = '{start: 1'b1, steps: CNT_W'(DVD_W)};
                    div_dividend = {mc_reg, QSHIFT'(0)};
                    div_divisor  = DVS_W'(norm_mant);
                    // request exponent kept in s_reg until the quotient is rounded
                    s_next       = norm_exp;
                    state_next   = S_DIV_Q;
                end
            end
            S_DIV_Q:
            begin
                if (div_done)
                    state_next = S_QRND;
            end
            S_QRND:
            begin
                mq_next    = qsum[MANT_W] ? qsum[MANT_W:1] : qsum[MANT_W-1:0];
                eq_next    = EXP_W'(qsh) + EXP_W'(qsum[MANT_W]) + EXP_W'(ec_reg)
                             - s_reg - EXP_W'(QSHIFT + 1);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                norm_start = 1'b1;
                norm_value = sum_val;
                s_next     = eq_ge_m1 ? EXP_W'(1) : EXP_W'(0) - eq_reg;
                state_next = S_NORM_S;
            end
            S_NORM_S:
            begin
                if (norm_done)
                begin
                    dv_next    = trunc_val[CLK_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dv_reg < MIN_DIVISOR)
                begin
                    st_next    = ST_TOO_FAST;
                    act_next   = '1;
                    dac_next   = '0;
                    bits_next  = '0;
                    fcnt_next  = fcnt_reg + CNTR_W'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    div_ctl    = '{start: 1'b1, steps: CNT_W'(CLK_W)};
                    state_next = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                if (div_done)
                begin
                    st_next    = ST_OK;
                    act_next   = {1'b0, div_quo};
                    dac_next   = dv_reg - CLK_W'(1);
                    bits_next  = BITS_W'(brc - 5'd1);
                    wcnt_next  = wcnt_reg + WRITE_INC;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(OUT_W - 2*CNTR_W - BITS_W - CLK_W - ACT_W - ST_W)'(0),
                                    fcnt_reg, wcnt_reg, bits_reg, dac_reg, act_reg, st_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            clk_cfg_reg <= CLK_RESET;
            wcnt_reg    <= '0;
            fcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wcnt_reg    <= wcnt_next;
            fcnt_reg    <= fcnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
                clk_cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        mc_reg     <= mc_next;
        ec_reg     <= ec_next;
        mq_reg     <= mq_next;
        eq_reg     <= eq_next;
        s_reg      <= s_next;
        dv_reg     <= dv_next;
        st_reg     <= st_next;
        act_reg    <= act_next;
        dac_reg    <= dac_next;
        bits_reg   <= bits_next;
    end

    asrd_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .value (norm_value),
        .mant  (norm_mant),
        .expo  (norm_exp),
        .done  (norm_done)
    );

    asrd_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (div_ctl),
        .dividend    (div_dividend),
        .divisor     (div_divisor),
        .quotient    (div_quo),
        .rem_nonzero (div_rem_nz),
        .done        (div_done)
    );

endmodule
